@@ rtl/transparent_pixel_box_fill_top_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the transparent pixel box fill block
// Clocked on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef TRANSPARENT_PIXEL_BOX_FILL_TOP_MACROS_SVH
`define TRANSPARENT_PIXEL_BOX_FILL_TOP_MACROS_SVH

// Same-cycle implication
`define TPBF_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define TPBF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/tpbf_pkg.sv @@
// ---------------------------------------------------------------------------
// tpbf_pkg
// Types and constants shared by the transparent pixel box fill block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package tpbf_pkg;

    localparam int WIN         = 3;
    localparam int MAX_HEIGHT  = 1024;
    localparam int CFG_W       = 11;
    localparam int CFG_RESET   = 1024;
    localparam int ROW_W       = 10;
    localparam int IN_ROW_W    = 11;
    localparam int PIX_W       = 32;
    localparam int SUM_W       = 12;
    localparam int CNT_W       = 4;
    localparam int RECIP_W     = 17;
    localparam int RECIP_SHIFT = 16;
    localparam int PROD_W      = SUM_W + RECIP_W;

    localparam int REG_INDEX_W = 1;
    localparam logic [REG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [REG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_DRAIN = 1'b1;

    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pixel_t;

    typedef struct packed {
        logic       req_type;
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
        logic [7:0] in_alpha;
    } req_t;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] out_alpha;
        logic       last_pixel;
    } rsp_t;

    // Which window rows and columns lie inside the frame
    typedef struct packed {
        logic row0_en;
        logic row2_en;
        logic col0_en;
        logic col2_en;
    } bound_mask_t;

    typedef struct packed {
        logic        shift;
        logic        sum;
        pixel_t      px;
        pixel_t      above;
        pixel_t      two_above;
        bound_mask_t mask;
    } win_ctrl_t;

    typedef struct packed {
        logic [SUM_W-1:0] red;
        logic [SUM_W-1:0] green;
        logic [SUM_W-1:0] blue;
        logic [CNT_W-1:0] count;
        pixel_t           center;
    } win_sum_t;

    // ceil(2^16 / d); exact quotient for sums below 2^12 and d in 1..9
    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] d);
        logic [RECIP_W-1:0] m;
        unique case (d)
            4'd2:    m = 17'd32768;
            4'd3:    m = 17'd21846;
            4'd4:    m = 17'd16384;
            4'd5:    m = 17'd13108;
            4'd6:    m = 17'd10923;
            4'd7:    m = 17'd9363;
            4'd8:    m = 17'd8192;
            4'd9:    m = 17'd7282;
            default: m = 17'd65536;
        endcase
        return m;
    endfunction

endpackage

@@ rtl/transparent_pixel_box_fill_top.sv @@
// ---------------------------------------------------------------------------
// transparent_pixel_box_fill_top
// Fills all-zero RGBA8 pixels with the average of nonzero-alpha 3x3 neighbors.
// ---------------------------------------------------------------------------
// A pixel that yields a transaction passes the window, sum and divide states, the
// divide state held while the output stalls; other pixels pass only the window
// state. A result leaves image_width+1 items after its pixel.
// Reset sets both size registers to 1024, clears positions, window and output
// valid; the line buffer RAM is not cleared and needs no clearing pass.
`timescale 1ns / 1ps

`include "transparent_pixel_box_fill_top_macros.svh"

module transparent_pixel_box_fill_top #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    output logic                             req_stall,
    input  tpbf_pkg::req_t                   req,
    output logic                             rsp_valid,
    input  logic                             rsp_stall,
    output tpbf_pkg::rsp_t                   rsp,
    input  logic                             cfg_we,
    input  logic [tpbf_pkg::REG_INDEX_W-1:0] cfg_index,
    input  logic [tpbf_pkg::CFG_W-1:0]       cfg_data
);

    localparam int COL_W = $clog2(MAX_WIDTH);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WIN  = 2'd1;
    localparam logic [1:0] ST_SUM  = 2'd2;
    localparam logic [1:0] ST_DIV  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    logic [tpbf_pkg::CFG_W-1:0] image_width_reg;
    logic [tpbf_pkg::CFG_W-1:0] image_height_reg;
    logic [tpbf_pkg::CFG_W-1:0] eff_w;
    logic [tpbf_pkg::CFG_W-1:0] eff_h;

    logic [COL_W-1:0]             in_col_reg;
    logic [COL_W-1:0]             in_col_next;
    logic [tpbf_pkg::IN_ROW_W-1:0] in_row_reg;
    logic [tpbf_pkg::IN_ROW_W-1:0] in_row_next;
    logic [COL_W-1:0]             out_col_reg;
    logic [COL_W-1:0]             out_col_next;
    logic [tpbf_pkg::ROW_W-1:0]   out_row_reg;
    logic [tpbf_pkg::ROW_W-1:0]   out_row_next;

    logic                  accept;
    logic                  in_frame;
    logic                  take;
    logic                  emit;
    logic                  last;
    logic                  in_col_wrap;
    logic                  out_col_wrap;
    logic                  out_free;
    tpbf_pkg::pixel_t      px_new;
    tpbf_pkg::bound_mask_t mask_new;

    tpbf_pkg::pixel_t      px_reg;
    logic [COL_W-1:0]      col_reg;
    logic                  emit_reg;
    logic                  last_reg;
    tpbf_pkg::bound_mask_t mask_reg;

    logic [2*tpbf_pkg::PIX_W-1:0] ram_rdata;
    logic [2*tpbf_pkg::PIX_W-1:0] ram_wdata;
    logic                         ram_we;
    tpbf_pkg::win_ctrl_t          win_ctrl;
    tpbf_pkg::win_sum_t           win_sum;
    logic                         div_load;

    // Effective frame size: clamp to 1..max
    always_comb
    begin
        if (image_width_reg == '0)
        begin
            eff_w = tpbf_pkg::CFG_W'(1);
        end
        else if (32'(image_width_reg) > 32'(MAX_WIDTH))
        begin
            eff_w = tpbf_pkg::CFG_W'(MAX_WIDTH);
        end
        else
        begin
            eff_w = image_width_reg;
        end

        if (image_height_reg == '0)
        begin
            eff_h = tpbf_pkg::CFG_W'(1);
        end
        else if (32'(image_height_reg) > 32'(tpbf_pkg::MAX_HEIGHT))
        begin
            eff_h = tpbf_pkg::CFG_W'(tpbf_pkg::MAX_HEIGHT);
        end
        else
        begin
            eff_h = image_height_reg;
        end
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign accept    = req_valid && !req_stall;
    assign in_frame  = (in_row_reg < eff_h);
    // Drop a drain while frame pixels are still expected
    assign take      = accept && !(in_frame && req.req_type == tpbf_pkg::REQ_DRAIN);
    assign emit      = !(in_row_reg == '0
                      || (in_row_reg == tpbf_pkg::IN_ROW_W'(1) && in_col_reg == '0));
    assign last      = (32'(out_row_reg) + 32'd1 == 32'(eff_h))
                    && (32'(out_col_reg) + 32'd1 == 32'(eff_w));

    assign in_col_wrap  = (32'(in_col_reg) + 32'd1 >= 32'(eff_w));
    assign out_col_wrap = (32'(out_col_reg) + 32'd1 >= 32'(eff_w));
    assign out_free     = !rsp_valid || !rsp_stall;

    always_comb
    begin
        if (in_frame)
        begin
            px_new.red   = req.in_red;
            px_new.green = req.in_green;
            px_new.blue  = req.in_blue;
            px_new.alpha = req.in_alpha;
        end
        else
        begin
            px_new = '0;
        end
        mask_new.row0_en = (out_row_reg != '0);
        mask_new.row2_en = (32'(out_row_reg) + 32'd1 < 32'(eff_h));
        mask_new.col0_en = (out_col_reg != '0);
        mask_new.col2_en = !out_col_wrap;
    end

    // Position counters
    always_comb
    begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (cfg_we)
        begin
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end
        else if (take)
        begin
            if (in_col_wrap)
            begin
                in_col_next = '0;
                in_row_next = in_row_reg + 1'b1;
            end
            else
            begin
                in_col_next = in_col_reg + 1'b1;
            end
            if (emit)
            begin
                if (last)
                begin
                    in_col_next  = '0;
                    in_row_next  = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                end
                else if (out_col_wrap)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + 1'b1;
                end
                else
                begin
                    out_col_next = out_col_reg + 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    state_next = ST_WIN;
                end
            end
            ST_WIN:
            begin
                state_next = emit_reg ? ST_SUM : ST_IDLE;
            end
            ST_SUM:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            image_width_reg  <= tpbf_pkg::CFG_W'(tpbf_pkg::CFG_RESET);
            image_height_reg <= tpbf_pkg::CFG_W'(tpbf_pkg::CFG_RESET);
            in_col_reg       <= '0;
            in_row_reg       <= '0;
            out_col_reg      <= '0;
            out_row_reg      <= '0;
            emit_reg         <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            if (cfg_we && cfg_index == tpbf_pkg::REG_IMAGE_WIDTH)
            begin
                image_width_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == tpbf_pkg::REG_IMAGE_HEIGHT)
            begin
                image_height_reg <= cfg_data;
            end
            if (take)
            begin
                emit_reg <= emit;
            end
        end
    end

    // Capture the transaction for the read-modify-write
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            px_reg   <= px_new;
            col_reg  <= in_col_reg;
            last_reg <= last;
            mask_reg <= mask_new;
        end
    end

    // Line buffers: upper half two rows above, lower half one row above
    assign ram_we    = (state_reg == ST_WIN);
    assign ram_wdata = {ram_rdata[tpbf_pkg::PIX_W-1:0], px_reg};

    tpbf_ram #(
        .WIDTH (2 * tpbf_pkg::PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (col_reg),
        .wdata (ram_wdata),
        .raddr (in_col_reg),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        win_ctrl.shift     = (state_reg == ST_WIN);
        win_ctrl.sum       = (state_reg == ST_SUM);
        win_ctrl.px        = px_reg;
        win_ctrl.above     = tpbf_pkg::pixel_t'(ram_rdata[tpbf_pkg::PIX_W-1:0]);
        win_ctrl.two_above = tpbf_pkg::pixel_t'(ram_rdata[2*tpbf_pkg::PIX_W-1:tpbf_pkg::PIX_W]);
        win_ctrl.mask      = mask_reg;
    end

    tpbf_win u_win (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (win_ctrl),
        .sum   (win_sum)
    );

    assign div_load = (state_reg == ST_DIV) && out_free;

    tpbf_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (div_load),
        .sum       (win_sum),
        .last      (last_reg),
        .rsp       (rsp),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall)
    );

    `TPBF_ASSERT_NEXT(a_win_exit, state_reg == ST_WIN, state_reg == ST_IDLE || state_reg == ST_SUM, "window stage left to a wrong state")
    `TPBF_ASSERT_NEXT(a_sum_to_div, state_reg == ST_SUM, state_reg == ST_DIV, "sum stage not followed by divide")
    `TPBF_ASSERT_NEXT(a_load_valid, div_load, rsp_valid, "loaded result not presented")
    `TPBF_ASSERT_IMP(a_in_col_bound, 1'b1, 32'(in_col_reg) < 32'(eff_w), "input column beyond width")
    `TPBF_ASSERT_IMP(a_out_row_bound, 1'b1, {1'b0, out_row_reg} < eff_h, "output row beyond height")

endmodule

@@ rtl/tpbf_ram.sv @@
// ---------------------------------------------------------------------------
// tpbf_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tpbf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/tpbf_win.sv @@
// ---------------------------------------------------------------------------
// tpbf_win
// 3x3 pixel window with masked sums of the nonzero-alpha neighbors.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tpbf_win (
    input  logic                clk,
    input  logic                rst_n,
    input  tpbf_pkg::win_ctrl_t ctrl,
    output tpbf_pkg::win_sum_t  sum
);

    tpbf_pkg::pixel_t win_reg [tpbf_pkg::WIN][tpbf_pkg::WIN];

    logic [tpbf_pkg::SUM_W-1:0] red_acc;
    logic [tpbf_pkg::SUM_W-1:0] green_acc;
    logic [tpbf_pkg::SUM_W-1:0] blue_acc;
    logic [tpbf_pkg::CNT_W-1:0] cnt_acc;
    tpbf_pkg::win_sum_t         sum_reg;

    // Shift left and insert the new column on the right
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < tpbf_pkg::WIN; r++)
            begin
                for (int c = 0; c < tpbf_pkg::WIN; c++)
                begin
                    win_reg[r][c] <= '0;
                end
            end
        end
        else if (ctrl.shift)
        begin
            for (int r = 0; r < tpbf_pkg::WIN; r++)
            begin
                for (int c = 0; c < tpbf_pkg::WIN - 1; c++)
                begin
                    win_reg[r][c] <= win_reg[r][c+1];
                end
            end
            win_reg[0][tpbf_pkg::WIN-1] <= ctrl.two_above;
            win_reg[1][tpbf_pkg::WIN-1] <= ctrl.above;
            win_reg[2][tpbf_pkg::WIN-1] <= ctrl.px;
        end
    end

    always_comb
    begin
        logic use_px;
        red_acc   = '0;
        green_acc = '0;
        blue_acc  = '0;
        cnt_acc   = '0;
        for (int r = 0; r < tpbf_pkg::WIN; r++)
        begin
            for (int c = 0; c < tpbf_pkg::WIN; c++)
            begin
                use_px = (win_reg[r][c].alpha != 8'd0)
                      && !(r == 0 && !ctrl.mask.row0_en)
                      && !(r == tpbf_pkg::WIN - 1 && !ctrl.mask.row2_en)
                      && !(c == 0 && !ctrl.mask.col0_en)
                      && !(c == tpbf_pkg::WIN - 1 && !ctrl.mask.col2_en);
                if (use_px)
                begin
                    red_acc   = red_acc + tpbf_pkg::SUM_W'(win_reg[r][c].red);
                    green_acc = green_acc + tpbf_pkg::SUM_W'(win_reg[r][c].green);
                    blue_acc  = blue_acc + tpbf_pkg::SUM_W'(win_reg[r][c].blue);
                    cnt_acc   = cnt_acc + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.sum)
        begin
            sum_reg.red    <= red_acc;
            sum_reg.green  <= green_acc;
            sum_reg.blue   <= blue_acc;
            sum_reg.count  <= cnt_acc;
            sum_reg.center <= win_reg[1][1];
        end
    end

    assign sum = sum_reg;

endmodule

@@ rtl/tpbf_div.sv @@
// ---------------------------------------------------------------------------
// tpbf_div
// Reciprocal divide of the window sums and the output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tpbf_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  tpbf_pkg::win_sum_t sum,
    input  logic               last,
    output tpbf_pkg::rsp_t     rsp,
    output logic               rsp_valid,
    input  logic               rsp_stall
);

    logic [tpbf_pkg::RECIP_W-1:0] m;
    logic [tpbf_pkg::PROD_W-1:0]  prod_red;
    logic [tpbf_pkg::PROD_W-1:0]  prod_green;
    logic [tpbf_pkg::PROD_W-1:0]  prod_blue;
    logic                         fill;
    tpbf_pkg::rsp_t               rsp_reg;
    logic                         rsp_valid_reg;

    assign m    = tpbf_pkg::recip(sum.count);
    assign fill = (sum.center == '0);

    assign prod_red   = tpbf_pkg::PROD_W'(sum.red) * tpbf_pkg::PROD_W'(m);
    assign prod_green = tpbf_pkg::PROD_W'(sum.green) * tpbf_pkg::PROD_W'(m);
    assign prod_blue  = tpbf_pkg::PROD_W'(sum.blue) * tpbf_pkg::PROD_W'(m);

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rsp_reg.out_red    <= fill ? prod_red[tpbf_pkg::RECIP_SHIFT +: 8]
                                       : sum.center.red;
            rsp_reg.out_green  <= fill ? prod_green[tpbf_pkg::RECIP_SHIFT +: 8]
                                       : sum.center.green;
            rsp_reg.out_blue   <= fill ? prod_blue[tpbf_pkg::RECIP_SHIFT +: 8]
                                       : sum.center.blue;
            rsp_reg.out_alpha  <= sum.center.alpha;
            rsp_reg.last_pixel <= last;
        end
    end

    // Hold the transaction until the consumer takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

endmodule
